[hw/rtl/cts_pkg.sv]
package cts_pkg;

  localparam int MAX_POLY_VERTS = 9;
  localparam int T_BITS = 30;
  localparam int NUM_REGS = 8;

  typedef logic [8:0][31:0] tri_t;
  typedef logic [NUM_REGS-1:0][63:0] mat_t;
  typedef logic [3:0][63:0] cvert_t;

  typedef struct packed {
    logic valid;
    tri_t data;
  } tri_req_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

[hw/rtl/cts_front.sv]
module cts_front import cts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tri_t     in_data,
  output tri_req_t q_o,
  input  logic     q_ready
);

  tri_t        mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_o.valid && q_ready;

  assign q_o.valid = (cnt_r != 2'd0);
  assign q_o.data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

endmodule

[hw/rtl/cts_mul.sv]
module cts_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic        [63:0] p_r
);

  logic signed [65:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p_r <= full[63:0];
  end

endmodule

[hw/rtl/cts_div.sv]
module cts_div import cts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done_r,
  output logic [63:0] quot_r
);

  typedef enum logic [1:0] {D_IDLE, D_NORM, D_DIV} dstate_t;

  dstate_t     state_r;
  logic [63:0] n_r, d_r;
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r[31:0], n_r[63]};
  assign ge     = rem_sh >= {1'b0, d_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == D_DIV) && (cnt_r == 6'd0);
      case (state_r)
        D_IDLE: begin
          if (start) begin
            n_r     <= num;
            d_r     <= den;
            state_r <= D_NORM;
          end
        end
        D_NORM: begin
          if (d_r[63:32] != 32'd0) begin
            n_r <= n_r >> 1;
            d_r <= d_r >> 1;
          end else begin
            n_r     <= n_r << T_BITS;
            rem_r   <= 33'd0;
            cnt_r   <= 6'd63;
            state_r <= D_DIV;
          end
        end
        D_DIV: begin
          rem_r  <= ge ? (rem_sh - {1'b0, d_r[31:0]}) : rem_sh;
          quot_r <= {quot_r[62:0], ge};
          n_r    <= n_r << 1;
          cnt_r  <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/cts_back.sv]
module cts_back import cts_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tri_req_t    q_i,
  output logic        q_ready,
  input  mat_t        mat_i,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_TMUL, S_TACC, S_CSTART, S_CCUR, S_TDIV, S_IMUL, S_IACC, S_CIN,
    S_ASTART, S_NDC, S_NWAIT, S_NSTORE, S_XM0, S_XM1, S_XA, S_FIN
  } state_t;

  localparam logic [3:0] MAXV = 4'(MAX_POLY_VERTS);

  state_t      state_r;
  tri_t        tri_r;
  cvert_t      poly_r [2][MAX_POLY_VERTS];
  logic        bank_r;
  logic [1:0]  vert_r, row_r, col_r;
  logic [2:0]  k_r, plane_r;
  logic [3:0]  n_r, m_r, i_r;
  logic [63:0] acc_r, dp_r, dc_r, t_r, ahi_r, alo_r, sum_r, p0_r;
  cvert_t      prev_r, cur_r;
  logic        ok_r, wrap_r, comp_r, xs_r;
  logic [31:0] q_r, px_r, py_r, cx_r, cy_r, fx_r;
  logic [31:0] fy_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;

  logic [3:0]         rd_idx, tidx, m_nxt;
  cvert_t             rd_v;
  logic [63:0]        dc_c, x_c, ax_c, prod, d_c, hi_c, tsum, ival, mg;
  logic [31:0]        mat_c, ndc_v;
  logic signed [32:0] mul_a, mul_b;
  logic               div_start, div_done;
  logic [63:0]        div_num, div_den, div_q;

  function automatic logic [31:0] mat_at(input mat_t m, input logic [1:0] r,
                                         input logic [1:0] c);
    logic [63:0] w;
    w = m[{c, r[1]}];
    mat_at = r[0] ? w[63:32] : w[31:0];
  endfunction

  function automatic logic [63:0] plane_dist(input cvert_t v, input logic [2:0] p);
    logic [63:0] c;
    c = v[p[2:1]];
    plane_dist = p[0] ? (v[3] - c) : (v[3] + c);
  endfunction

  function automatic logic [63:0] sx64(input logic [31:0] v);
    sx64 = {{32{v[31]}}, v};
  endfunction

  assign rd_idx = (state_r == S_CSTART) ? 4'(n_r - 4'd1) : i_r;
  assign rd_v   = poly_r[bank_r][rd_idx];
  assign dc_c   = plane_dist(rd_v, plane_r);
  assign tidx   = 4'({2'b00, vert_r} * 4'd3) + {2'b00, col_r};
  assign mat_c  = mat_at(mat_i, row_r, (state_r == S_TACC && col_r == 2'd0) ? 2'd3 : col_r);
  assign d_c    = cur_r[row_r] - prev_r[row_r];
  assign hi_c   = 64'($signed(d_c) >>> T_BITS);
  assign x_c    = comp_r ? rd_v[1] : rd_v[0];
  assign ax_c   = mag64(x_c);
  assign tsum   = ((col_r == 2'd0) ? sx64(mat_c) : acc_r)
                  + 64'($signed(prod) >>> FRAC_BITS);
  assign ival   = prev_r[row_r] + ahi_r + ((alo_r + {prod[31:0], 32'd0}) >> T_BITS);
  assign ndc_v  = xs_r ? (32'd0 - q_r) : q_r;
  assign mg     = mag64(sum_r) >> 1;
  assign m_nxt  = (!dc_r[63] && m_r < MAXV) ? 4'(m_r + 4'd1) : m_r;

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (state_r)
      S_TMUL: begin
        mul_a = {mat_c[31], mat_c};
        mul_b = {tri_r[tidx][31], tri_r[tidx]};
      end
      S_IMUL: begin
        case (k_r)
          3'd0: begin mul_a = {1'b0, hi_c[31:0]}; mul_b = {1'b0, t_r[31:0]}; end
          3'd1: begin mul_a = {1'b0, hi_c[31:0]}; mul_b = {1'b0, t_r[63:32]}; end
          3'd2: begin mul_a = {1'b0, hi_c[63:32]}; mul_b = {1'b0, t_r[31:0]}; end
          3'd3: begin mul_a = {3'b000, d_c[29:0]}; mul_b = {1'b0, t_r[31:0]}; end
          default: begin mul_a = {3'b000, d_c[29:0]}; mul_b = {1'b0, t_r[63:32]}; end
        endcase
      end
      S_XM0: begin
        mul_a = {px_r[31], px_r};
        mul_b = {cy_r[31], cy_r};
      end
      S_XM1: begin
        mul_a = {cx_r[31], cx_r};
        mul_b = {py_r[31], py_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = ax_c;
    div_den   = rd_v[3];
    if (state_r == S_CCUR && (dp_r[63] != dc_c[63])) begin
      div_start = 1'b1;
      div_num   = mag64(dp_r);
      div_den   = mag64(dp_r - dc_c);
    end else if (state_r == S_NDC && !(ax_c >= rd_v[3])) begin
      div_start = 1'b1;
    end
  end

  cts_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  cts_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done_r (div_done),
    .quot_r (div_q)
  );

  assign q_ready    = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_i.valid && !out_valid_r) begin
            tri_r   <= q_i.data;
            vert_r  <= 2'd0;
            row_r   <= 2'd0;
            col_r   <= 2'd0;
            bank_r  <= 1'b0;
            state_r <= S_TMUL;
          end
        end
        S_TMUL: state_r <= S_TACC;
        S_TACC: begin
          acc_r <= tsum;
          if (col_r == 2'd2) begin
            poly_r[1'b0][4'(vert_r)][row_r] <= tsum;
            col_r <= 2'd0;
            row_r <= row_r + 2'd1;
            if (row_r == 2'd3) begin
              vert_r <= vert_r + 2'd1;
              if (vert_r == 2'd2) begin
                n_r     <= 4'd3;
                plane_r <= 3'd0;
                state_r <= S_CSTART;
              end else begin
                state_r <= S_TMUL;
              end
            end else begin
              state_r <= S_TMUL;
            end
          end else begin
            col_r   <= col_r + 2'd1;
            state_r <= S_TMUL;
          end
        end
        S_CSTART: begin
          if (plane_r == 3'd6 || n_r == 4'd0) begin
            state_r <= S_ASTART;
          end else begin
            prev_r  <= rd_v;
            dp_r    <= dc_c;
            m_r     <= 4'd0;
            i_r     <= 4'd0;
            state_r <= S_CCUR;
          end
        end
        S_CCUR: begin
          cur_r   <= rd_v;
          dc_r    <= dc_c;
          state_r <= (dp_r[63] != dc_c[63]) ? S_TDIV : S_CIN;
        end
        S_TDIV: begin
          if (div_done) begin
            t_r     <= div_q;
            row_r   <= 2'd0;
            k_r     <= 3'd0;
            state_r <= (m_r < MAXV) ? S_IMUL : S_CIN;
          end
        end
        S_IMUL: state_r <= S_IACC;
        S_IACC: begin
          case (k_r)
            3'd0: ahi_r <= prod;
            3'd1, 3'd2: ahi_r <= ahi_r + {prod[31:0], 32'd0};
            3'd3: alo_r <= prod;
            default: ;
          endcase
          if (k_r == 3'd4) begin
            poly_r[~bank_r][m_r][row_r] <= ival;
            k_r <= 3'd0;
            if (row_r == 2'd3) begin
              m_r     <= m_r + 4'd1;
              state_r <= S_CIN;
            end else begin
              row_r   <= row_r + 2'd1;
              state_r <= S_IMUL;
            end
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= S_IMUL;
          end
        end
        S_CIN: begin
          if (!dc_r[63] && m_r < MAXV) begin
            poly_r[~bank_r][m_r] <= cur_r;
          end
          m_r    <= m_nxt;
          prev_r <= cur_r;
          dp_r   <= dc_r;
          if (i_r == 4'(n_r - 4'd1)) begin
            bank_r  <= ~bank_r;
            n_r     <= m_nxt;
            plane_r <= plane_r + 3'd1;
            state_r <= S_CSTART;
          end else begin
            i_r     <= i_r + 4'd1;
            state_r <= S_CCUR;
          end
        end
        S_ASTART: begin
          sum_r  <= 64'd0;
          i_r    <= 4'd0;
          wrap_r <= 1'b0;
          comp_r <= 1'b0;
          ok_r   <= (n_r >= 4'd3);
          state_r <= (n_r >= 4'd3) ? S_NDC : S_FIN;
        end
        S_NDC: begin
          if (!comp_r && $signed(rd_v[3]) <= 64'sd0) begin
            ok_r <= 1'b0;
          end
          xs_r <= x_c[63];
          if (ax_c >= rd_v[3]) begin
            q_r     <= 32'd1 << T_BITS;
            state_r <= S_NSTORE;
          end else begin
            state_r <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          if (div_done) begin
            q_r     <= div_q[31:0];
            state_r <= S_NSTORE;
          end
        end
        S_NSTORE: begin
          if (!comp_r) begin
            cx_r    <= ndc_v;
            comp_r  <= 1'b1;
            state_r <= S_NDC;
          end else begin
            cy_r   <= ndc_v;
            comp_r <= 1'b0;
            if (i_r == 4'd0) begin
              fx_r    <= cx_r;
              fy_r    <= ndc_v;
              px_r    <= cx_r;
              py_r    <= ndc_v;
              i_r     <= 4'd1;
              state_r <= S_NDC;
            end else begin
              state_r <= S_XM0;
            end
          end
        end
        S_XM0: state_r <= S_XM1;
        S_XM1: begin
          p0_r    <= prod;
          state_r <= S_XA;
        end
        S_XA: begin
          sum_r <= sum_r + 64'($signed(p0_r - prod) >>> T_BITS);
          if (wrap_r) begin
            state_r <= S_FIN;
          end else begin
            px_r <= cx_r;
            py_r <= cy_r;
            if (i_r == 4'(n_r - 4'd1)) begin
              wrap_r  <= 1'b1;
              cx_r    <= fx_r;
              cy_r    <= fy_r;
              state_r <= S_XM0;
            end else begin
              i_r     <= i_r + 4'd1;
              state_r <= S_NDC;
            end
          end
        end
        S_FIN: begin
          out_data_r[35:32] <= n_r;
          out_data_r[39:36] <= 4'd0;
          if (!ok_r) begin
            out_data_r[31:0] <= 32'd0;
          end else if (mg[63:32] != 32'd0) begin
            out_data_r[31:0] <= 32'hFFFF_FFFF;
          end else begin
            out_data_r[31:0] <= mg[31:0];
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/clipped_triangle_screen_area.sv]
// Steps: transform, clip per vertex and plane with a divide at each edge crossing, then the NDC divides.
// Throughput: one triangle at a time through the back end; the shared 1-bit-per-cycle
// divider sets the figure. A 2-deep input queue and the output register decouple the ports.
// Reset: synchronous active-low; clears control state and loads the identity matrix.
module clipped_triangle_screen_area import cts_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // screen_area, clipped_count, zero pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam mat_t MAT_RESET = {
    64'd1 << (32 + FRAC_BITS), 64'd0, 64'd1 << FRAC_BITS, 64'd0,
    64'd0, 64'd1 << (32 + FRAC_BITS), 64'd0, 64'd1 << FRAC_BITS
  };

  mat_t     matrix_r;
  tri_req_t q;
  logic     q_ready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = matrix_r[cfg_paddr[5:3]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= MAT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      matrix_r[cfg_paddr[5:3]] <= cfg_pwdata;
    end
  end

  cts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .q_o      (q),
    .q_ready  (q_ready)
  );

  cts_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_i        (q),
    .q_ready    (q_ready),
    .mat_i      (matrix_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
